### rtl/htd_pkg.sv
// htd_pkg: shared types and constants of the huffman tree decoder
// node memory layout, result kinds, field widths
// no dependencies
package htd_pkg;

  localparam int NODE_COUNT   = 512;
  localparam int MAX_CODE_LEN = 24;

  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int CNT_W       = $clog2(NODE_COUNT + 1);
  localparam int LEN_W       = $clog2(MAX_CODE_LEN + 1);
  localparam int SYM_W       = 8;
  localparam int CODE_W      = 24;
  localparam int CODE_IDX_W  = $clog2(CODE_W);
  localparam int CLEN_W      = 5;
  localparam int BYTE_W      = 8;
  localparam int BIT_IDX_W   = $clog2(BYTE_W);
  localparam int KIND_W      = 2;
  localparam int NODE_BITS   = 2 * NODE_W + SYM_W;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  localparam logic             FUNC_LOAD   = 1'b0;
  localparam logic             FUNC_DECODE = 1'b1;
  localparam logic [SYM_W-1:0] END_SYMBOL  = 8'h00;

  typedef enum logic [KIND_W-1:0] {
    KIND_SYMBOL  = 2'd0,
    KIND_END     = 2'd1,
    KIND_MISSING = 2'd2,
    KIND_FULL    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic [SYM_W-1:0]  symbol;
  } node_t;

endpackage

### rtl/htd_ram.sv
// htd_ram: generic single write port, single read port ram
// registered read data, updated only on a read enable
// no dependencies
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/huffman_tree_decoder_unit.sv
// huffman_tree_decoder_unit: huffman decoder over a binary tree in a node memory
// uses htd_pkg for types and constants, htd_ram for the node memory
//
// in channel: in_tuser selects the word kind, 0 loads one code into the tree,
// 1 decodes one compressed byte msb first. in_tready is high only while the
// sequencer is idle; one word is in work at a time.
// out channel: one word per decoded symbol, end marker, missing branch or
// full node store; out_tlast marks the final word caused by an input word.
// a load reads one node per code bit, plus a final read and symbol write,
// code_length capped at 24; a full store ends it early through the flush
// state. a decode reads the walk node, then one node per bit, rereads the
// root after each leaf reached before the last bit, and ends in the flush
// state; a missing branch or the end marker cuts the byte short. once the
// end marker is seen, decode words are taken and dropped until reset.
// results are held one deep before the output register so that out_tlast can
// be set; when out_tready is low the sequencer waits before the next result.
// reset empties the tree at once: only the root and allocated nodes are ever
// read and a fresh node reads as zero until its first write, so the node memory
// needs no clearing pass. in_tready is high from the first cycle after reset.
module huffman_tree_decoder_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // symbol[7:0], code_bits[31:8], code_length[36:32], data_byte[44:37], zero pad
  input  logic [htd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_symbol[7:0]
  output logic [htd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // kind[1:0]
  output logic [htd_pkg::KIND_W-1:0]         out_tuser,
  output logic                               out_tlast
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LRD   = 8'b0000_0010,
    S_LEVAL = 8'b0000_0100,
    S_DRD   = 8'b0000_1000,
    S_DLD   = 8'b0001_0000,
    S_DSTEP = 8'b0010_0000,
    S_DCHK  = 8'b0100_0000,
    S_FLUSH = 8'b1000_0000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [htd_pkg::SYM_W-1:0]        symbol_r, symbol_nxt;
  logic [htd_pkg::CODE_W-1:0]       code_r, code_nxt;
  logic [htd_pkg::LEN_W-1:0]        len_r, len_nxt;
  logic [htd_pkg::BYTE_W-1:0]       byte_r, byte_nxt;
  logic [htd_pkg::BIT_IDX_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [htd_pkg::NODE_W-1:0]       now_r, now_nxt;
  logic [htd_pkg::NODE_W-1:0]       walk_r, walk_nxt;
  logic [htd_pkg::NODE_W-1:0]       child_r, child_nxt;
  logic [htd_pkg::NODE_W-1:0]       rd_addr_r, rd_addr_nxt;
  htd_pkg::node_t                   node_r, node_nxt;
  logic [htd_pkg::CNT_W-1:0]        next_free_r, next_free_nxt;
  logic                             fresh_r, fresh_nxt;
  logic                             ended_r, ended_nxt;
  logic                             pend_v_r, pend_v_nxt;
  htd_pkg::kind_t                   pend_kind_r, pend_kind_nxt;
  logic [htd_pkg::SYM_W-1:0]        pend_sym_r, pend_sym_nxt;
  logic                             out_v_r, out_v_nxt;
  htd_pkg::kind_t                   out_kind_r, out_kind_nxt;
  logic [htd_pkg::SYM_W-1:0]        out_sym_r, out_sym_nxt;
  logic                             out_last_r, out_last_nxt;

  logic                             ram_we, ram_re;
  logic [htd_pkg::NODE_W-1:0]       ram_waddr, ram_raddr;
  htd_pkg::node_t                   ram_wdata;
  logic [htd_pkg::NODE_BITS-1:0]    ram_rdata;

  htd_pkg::node_t                   node_rd;
  logic                             fresh_hit;
  logic                             out_free, emit_ok;
  logic                             emit_req;
  htd_pkg::kind_t                   emit_kind;
  logic [htd_pkg::SYM_W-1:0]        emit_sym;
  logic                             alloc;
  logic                             code_bit, byte_bit, leaf, last_bit;
  logic [31:0]                      pos;
  logic [htd_pkg::NODE_W-1:0]       sel_child;
  logic [htd_pkg::NODE_W-1:0]       new_node;
  logic [htd_pkg::CLEN_W-1:0]       in_clen;

  htd_ram #(
    .WIDTH (htd_pkg::NODE_BITS),
    .DEPTH (htd_pkg::NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a freshly allocated node reads as empty until first written
  assign fresh_hit = fresh_r &&
                     (htd_pkg::CNT_W'(rd_addr_r) == next_free_r - htd_pkg::CNT_W'(1));
  assign node_rd   = fresh_hit ? '0 : htd_pkg::node_t'(ram_rdata);

  assign out_free  = !out_v_r || out_tready;
  assign emit_ok   = !pend_v_r || out_free;
  assign in_tready = (state_r == S_IDLE);
  assign in_clen   = in_tdata[36:32];
  assign new_node  = next_free_r[htd_pkg::NODE_W-1:0];

  assign pos      = 32'(len_r) - 32'd1;
  assign code_bit = (pos < 32'(htd_pkg::CODE_W)) ? code_r[pos[htd_pkg::CODE_IDX_W-1:0]] : 1'b0;
  assign byte_bit = byte_r[htd_pkg::BYTE_W-1];
  assign last_bit = (bit_cnt_r == htd_pkg::BIT_IDX_W'(htd_pkg::BYTE_W - 1));
  assign leaf     = (node_rd.left == '0) && (node_rd.right == '0);

  always_comb begin
    state_nxt     = state_r;
    symbol_nxt    = symbol_r;
    code_nxt      = code_r;
    len_nxt       = len_r;
    byte_nxt      = byte_r;
    bit_cnt_nxt   = bit_cnt_r;
    now_nxt       = now_r;
    walk_nxt      = walk_r;
    child_nxt     = child_r;
    rd_addr_nxt   = rd_addr_r;
    node_nxt      = node_r;
    next_free_nxt = next_free_r;
    fresh_nxt     = fresh_r;
    ended_nxt     = ended_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_sym_nxt  = pend_sym_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = now_r;
    ram_wdata     = node_rd;
    ram_re        = 1'b0;
    ram_raddr     = now_r;
    emit_req      = 1'b0;
    emit_kind     = htd_pkg::KIND_SYMBOL;
    emit_sym      = '0;
    alloc         = 1'b0;
    sel_child     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          symbol_nxt = in_tdata[7:0];
          code_nxt   = in_tdata[31:8];
          byte_nxt   = in_tdata[44:37];
          if (int'(in_clen) > htd_pkg::MAX_CODE_LEN) begin
            len_nxt = htd_pkg::LEN_W'(htd_pkg::MAX_CODE_LEN);
          end else begin
            len_nxt = htd_pkg::LEN_W'(in_clen);
          end
          bit_cnt_nxt = '0;
          now_nxt     = '0;
          if (in_tuser == htd_pkg::FUNC_LOAD) begin
            state_nxt = S_LRD;
          end else if (!ended_r) begin
            state_nxt = S_DRD;
          end
        end
      end

      S_LRD: begin
        ram_re      = 1'b1;
        ram_raddr   = now_r;
        rd_addr_nxt = now_r;
        state_nxt   = S_LEVAL;
      end

      S_LEVAL: begin
        sel_child = code_bit ? node_rd.right : node_rd.left;
        if (len_r == '0) begin
          ram_we           = 1'b1;
          ram_waddr        = now_r;
          ram_wdata        = node_rd;
          ram_wdata.symbol = symbol_r;
          state_nxt        = S_IDLE;
        end else if (sel_child != '0) begin
          now_nxt   = sel_child;
          len_nxt   = len_r - htd_pkg::LEN_W'(1);
          state_nxt = S_LRD;
        end else if (next_free_r == htd_pkg::CNT_W'(htd_pkg::NODE_COUNT)) begin
          emit_req  = 1'b1;
          emit_kind = htd_pkg::KIND_FULL;
          state_nxt = S_FLUSH;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = now_r;
          ram_wdata = node_rd;
          if (code_bit) begin
            ram_wdata.right = new_node;
          end else begin
            ram_wdata.left = new_node;
          end
          alloc         = 1'b1;
          now_nxt       = new_node;
          next_free_nxt = next_free_r + htd_pkg::CNT_W'(1);
          len_nxt       = len_r - htd_pkg::LEN_W'(1);
          state_nxt     = S_LRD;
        end
      end

      S_DRD: begin
        ram_re      = 1'b1;
        ram_raddr   = walk_r;
        rd_addr_nxt = walk_r;
        state_nxt   = S_DLD;
      end

      S_DLD: begin
        node_nxt  = node_rd;
        state_nxt = S_DSTEP;
      end

      S_DSTEP: begin
        sel_child = byte_bit ? node_r.right : node_r.left;
        if (sel_child == '0) begin
          if (emit_ok) begin
            emit_req  = 1'b1;
            emit_kind = htd_pkg::KIND_MISSING;
            walk_nxt  = '0;
            state_nxt = S_FLUSH;
          end
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = sel_child;
          rd_addr_nxt = sel_child;
          child_nxt   = sel_child;
          state_nxt   = S_DCHK;
        end
      end

      S_DCHK: begin
        if (leaf) begin
          if (emit_ok) begin
            emit_req = 1'b1;
            walk_nxt = '0;
            if (node_rd.symbol == htd_pkg::END_SYMBOL) begin
              emit_kind = htd_pkg::KIND_END;
              ended_nxt = 1'b1;
              state_nxt = S_FLUSH;
            end else begin
              emit_kind = htd_pkg::KIND_SYMBOL;
              emit_sym  = node_rd.symbol;
              if (last_bit) begin
                state_nxt = S_FLUSH;
              end else begin
                bit_cnt_nxt = bit_cnt_r + htd_pkg::BIT_IDX_W'(1);
                byte_nxt    = byte_r << 1;
                state_nxt   = S_DRD;
              end
            end
          end
        end else begin
          node_nxt = node_rd;
          walk_nxt = child_r;
          if (last_bit) begin
            state_nxt = S_FLUSH;
          end else begin
            bit_cnt_nxt = bit_cnt_r + htd_pkg::BIT_IDX_W'(1);
            byte_nxt    = byte_r << 1;
            state_nxt   = S_DSTEP;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_kind_nxt = pend_kind_r;
          out_sym_nxt  = pend_sym_r;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // held result moves out as a non-final word when a newer one arrives
    if (emit_req) begin
      if (pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_kind_nxt = pend_kind_r;
        out_sym_nxt  = pend_sym_r;
        out_last_nxt = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_kind_nxt = emit_kind;
      pend_sym_nxt  = emit_sym;
    end

    if (alloc) begin
      fresh_nxt = 1'b1;
    end else if (ram_we &&
                 (htd_pkg::CNT_W'(ram_waddr) == next_free_r - htd_pkg::CNT_W'(1))) begin
      fresh_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_free_r <= htd_pkg::CNT_W'(1);
      fresh_r     <= 1'b1;
      ended_r     <= 1'b0;
      walk_r      <= '0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_free_r <= next_free_nxt;
      fresh_r     <= fresh_nxt;
      ended_r     <= ended_nxt;
      walk_r      <= walk_nxt;
      pend_v_r    <= pend_v_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    symbol_r    <= symbol_nxt;
    code_r      <= code_nxt;
    len_r       <= len_nxt;
    byte_r      <= byte_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    now_r       <= now_nxt;
    child_r     <= child_nxt;
    rd_addr_r   <= rd_addr_nxt;
    node_r      <= node_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_sym_r  <= pend_sym_nxt;
    out_kind_r  <= out_kind_nxt;
    out_sym_r   <= out_sym_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_sym_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= htd_pkg::CNT_W'(htd_pkg::NODE_COUNT))
    else $error("node allocation count beyond store size");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("held result left over while idle");

  a_end_held: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ended_r) |-> (pend_v_r && (pend_kind_r == htd_pkg::KIND_END)))
    else $error("stream ended without an end marker result");

  a_flush_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && !pend_v_r) |=> (state_r == S_IDLE))
    else $error("flush with nothing held did not return to idle");
`endif

endmodule
